/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

/* hdl/sip_pkg.sv */
package sip_pkg;
   // stage tag carried alongside each request
   typedef struct packed {
      logic valid;
   } stage_ctl_type;
endpackage

/* hdl/segment_intersection_point.sv */
// Throughput: one request per cycle; busy is never raised.
// The quotient pipeline, one bit per stage, sets the latency.
// Synchronous reset clears all valid bits; no results are lost to stalls
// since the receiver cannot hold results off.
module segment_intersection_point #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_start_x,
   input  logic signed [COORD_BITS-1:0] req_a_start_y,
   input  logic signed [COORD_BITS-1:0] req_a_end_x,
   input  logic signed [COORD_BITS-1:0] req_a_end_y,
   input  logic signed [COORD_BITS-1:0] req_b_start_x,
   input  logic signed [COORD_BITS-1:0] req_b_start_y,
   input  logic signed [COORD_BITS-1:0] req_b_end_x,
   input  logic signed [COORD_BITS-1:0] req_b_end_y,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic signed [COORD_BITS-1:0] rsp_touch_x,
   output logic signed [COORD_BITS-1:0] rsp_touch_y
);
   import sip_pkg::*;
   localparam int DB = COORD_BITS + 1;      // differences
   localparam int PB = 2 * DB;              // products
   localparam int CB = PB + 1;              // cross products
   localparam int DNB = CB + 1;             // |c2 - c1|
   localparam int NB = CB + COORD_BITS;     // |u| * |c1|
   localparam int TW = 2 * COORD_BITS + 3;  // tag through divider

   assign busy = 1'b0;

   // stage 1: differences
   stage_ctl_type s1_ff;
   logic signed [DB-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [DB-1:0] bsax_ff, bsay_ff, beax_ff, beay_ff;
   logic signed [DB-1:0] asbx_ff, asby_ff, aebx_ff, aeby_ff;
   logic signed [COORD_BITS-1:0] asx1_ff, asy1_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_ff.valid <= 1'b0;
      else s1_ff.valid <= start & ~busy;
      ux_ff <= DB'(req_a_end_x) - DB'(req_a_start_x);
      uy_ff <= DB'(req_a_end_y) - DB'(req_a_start_y);
      vx_ff <= DB'(req_b_end_x) - DB'(req_b_start_x);
      vy_ff <= DB'(req_b_end_y) - DB'(req_b_start_y);
      bsax_ff <= DB'(req_b_start_x) - DB'(req_a_start_x);
      bsay_ff <= DB'(req_b_start_y) - DB'(req_a_start_y);
      beax_ff <= DB'(req_b_end_x) - DB'(req_a_start_x);
      beay_ff <= DB'(req_b_end_y) - DB'(req_a_start_y);
      asbx_ff <= DB'(req_a_start_x) - DB'(req_b_start_x);
      asby_ff <= DB'(req_a_start_y) - DB'(req_b_start_y);
      aebx_ff <= DB'(req_a_end_x) - DB'(req_b_start_x);
      aeby_ff <= DB'(req_a_end_y) - DB'(req_b_start_y);
      asx1_ff <= req_a_start_x;
      asy1_ff <= req_a_start_y;
   end

   // stage 2: products
   stage_ctl_type s2_ff;
   logic signed [PB-1:0] prod_ff [8];
   logic signed [DB-1:0] ux2_ff, uy2_ff;
   logic signed [COORD_BITS-1:0] asx2_ff, asy2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_ff.valid <= 1'b0;
      else s2_ff.valid <= s1_ff.valid;
      prod_ff[0] <= PB'(ux_ff) * PB'(beay_ff); prod_ff[1] <= PB'(uy_ff) * PB'(beax_ff);
      prod_ff[2] <= PB'(ux_ff) * PB'(bsay_ff); prod_ff[3] <= PB'(uy_ff) * PB'(bsax_ff);
      prod_ff[4] <= PB'(vx_ff) * PB'(asby_ff); prod_ff[5] <= PB'(vy_ff) * PB'(asbx_ff);
      prod_ff[6] <= PB'(vx_ff) * PB'(aeby_ff); prod_ff[7] <= PB'(vy_ff) * PB'(aebx_ff);
      ux2_ff <= ux_ff; uy2_ff <= uy_ff;
      asx2_ff <= asx1_ff; asy2_ff <= asy1_ff;
   end

   // stage 3: cross products
   stage_ctl_type s3_ff;
   logic signed [CB-1:0] p1_ff, p2_ff, c1_ff, c2_ff;
   logic signed [DB-1:0] ux3_ff, uy3_ff;
   logic signed [COORD_BITS-1:0] asx3_ff, asy3_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_ff.valid <= 1'b0;
      else s3_ff.valid <= s2_ff.valid;
      p1_ff <= CB'(prod_ff[2]) - CB'(prod_ff[3]);
      p2_ff <= CB'(prod_ff[0]) - CB'(prod_ff[1]);
      c1_ff <= CB'(prod_ff[4]) - CB'(prod_ff[5]);
      c2_ff <= CB'(prod_ff[6]) - CB'(prod_ff[7]);
      ux3_ff <= ux2_ff; uy3_ff <= uy2_ff;
      asx3_ff <= asx2_ff; asy3_ff <= asy2_ff;
   end

   // stage 4: hit decision, magnitudes
   stage_ctl_type s4_ff;
   logic hit4_ff;
   logic [CB-1:0] ac1_ff;
   logic [DNB-1:0] den_ff;
   logic [COORD_BITS:0] mux_ff, muy_ff;
   logic sx4_ff, sy4_ff;
   logic signed [COORD_BITS-1:0] asx4_ff, asy4_ff;
   logic signed [DNB-1:0] dd_in;
   always_comb dd_in = DNB'(c2_ff) - DNB'(c1_ff);
   always_ff @(posedge clock) begin
      if (reset) s4_ff.valid <= 1'b0;
      else s4_ff.valid <= s3_ff.valid;
      hit4_ff <= (p1_ff != '0) && (p2_ff != '0) && (p1_ff[CB-1] != p2_ff[CB-1]) &&
                 (c1_ff != '0) && (c2_ff != '0) && (c1_ff[CB-1] != c2_ff[CB-1]);
      ac1_ff <= c1_ff[CB-1] ? CB'(-c1_ff) : CB'(c1_ff);
      den_ff <= dd_in[DNB-1] ? DNB'(-dd_in) : DNB'(dd_in);
      mux_ff <= ux3_ff[DB-1] ? (COORD_BITS+1)'(-ux3_ff) : (COORD_BITS+1)'(ux3_ff);
      muy_ff <= uy3_ff[DB-1] ? (COORD_BITS+1)'(-uy3_ff) : (COORD_BITS+1)'(uy3_ff);
      sx4_ff <= ux3_ff[DB-1]; sy4_ff <= uy3_ff[DB-1];
      asx4_ff <= asx3_ff; asy4_ff <= asy3_ff;
   end

   // stage 5: numerators (quotient < |u| < 2^COORD_BITS)
   stage_ctl_type s5_ff;
   logic [NB-1:0] nx_ff, ny_ff;
   logic [DNB-1:0] den5_ff;
   logic [TW-1:0] tag5_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_ff.valid <= 1'b0;
      else s5_ff.valid <= s4_ff.valid;
      nx_ff <= NB'(mux_ff) * NB'(ac1_ff);
      ny_ff <= NB'(muy_ff) * NB'(ac1_ff);
      den5_ff <= hit4_ff ? den_ff : DNB'(1);
      tag5_ff <= {hit4_ff, sx4_ff, sy4_ff, asx4_ff, asy4_ff};
   end

   logic dvx, dvy;
   logic [COORD_BITS-1:0] qx, qy;
   logic [TW-1:0] tagx;
   logic tagy;
   sip_div #(.NUM_BITS(NB), .DEN_BITS(DNB), .Q_BITS(COORD_BITS), .TAG_BITS(TW)) u_divx (
      .clock(clock), .reset(reset), .in_valid(s5_ff.valid), .in_num(nx_ff),
      .in_den(den5_ff), .in_tag(tag5_ff), .out_valid(dvx), .out_quo(qx), .out_tag(tagx));
   sip_div #(.NUM_BITS(NB), .DEN_BITS(DNB), .Q_BITS(COORD_BITS), .TAG_BITS(1)) u_divy (
      .clock(clock), .reset(reset), .in_valid(s5_ff.valid), .in_num(ny_ff),
      .in_den(den5_ff), .in_tag(1'b0), .out_valid(dvy), .out_quo(qy), .out_tag(tagy));

   // output stage: apply direction sign, zero on miss
   logic hit_o;
   logic sxo, syo;
   logic [COORD_BITS-1:0] aso_x, aso_y;
   assign {hit_o, sxo, syo, aso_x, aso_y} = tagx;
   logic valid_ff, hit_ff;
   logic [COORD_BITS-1:0] tx_ff, ty_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= dvx & dvy & ~tagy;
      hit_ff <= hit_o;
      tx_ff <= hit_o ? (sxo ? aso_x - qx : aso_x + qx) : '0;
      ty_ff <= hit_o ? (syo ? aso_y - qy : aso_y + qy) : '0;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_touch_x = tx_ff;
   assign rsp_touch_y = ty_ff;
endmodule

/* hdl/sip_div.sv */
// Pipelined restoring divider: one quotient bit per stage, unsigned.
module sip_div #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 36,
   parameter int Q_BITS = 16,
   parameter int TAG_BITS = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output logic [Q_BITS-1:0]   out_quo,
   output logic [TAG_BITS-1:0] out_tag
);
   import sip_pkg::*;
   localparam int RW = DEN_BITS + 1;

   logic [Q_BITS:0]                 vld_ff;
   logic [Q_BITS:0][NUM_BITS-1:0]   num_ff;
   logic [Q_BITS:0][RW-1:0]         rem_ff;
   logic [Q_BITS:0][DEN_BITS-1:0]   den_ff;
   logic [Q_BITS:0][Q_BITS-1:0]     quo_ff;
   logic [Q_BITS:0][TAG_BITS-1:0]   tag_ff;
   logic [Q_BITS-1:0][RW-1:0]       rem_in;
   logic [Q_BITS-1:0][RW:0]         dif_in;

   // top bits above the quotient range are preloaded; the caller must keep them below den, the divider does not check
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[Q_BITS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= in_num;
      rem_ff[0] <= RW'(in_num >> Q_BITS);
      den_ff[0] <= in_den;
      quo_ff[0] <= '0;
      tag_ff[0] <= in_tag;
   end

   for (genvar s = 0; s < Q_BITS; s++) begin : g_step
      always_comb begin
         rem_in[s] = {rem_ff[s][RW-2:0], num_ff[s][Q_BITS-1-s]};
         dif_in[s] = {1'b0, rem_in[s]} - {2'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         num_ff[s+1] <= num_ff[s];
         den_ff[s+1] <= den_ff[s];
         tag_ff[s+1] <= tag_ff[s];
         rem_ff[s+1] <= dif_in[s][RW] ? rem_in[s] : dif_in[s][RW-1:0];
         quo_ff[s+1] <= {quo_ff[s][Q_BITS-2:0], ~dif_in[s][RW]};
      end
   end

   assign out_valid = vld_ff[Q_BITS];
   assign out_quo   = quo_ff[Q_BITS];
   assign out_tag   = tag_ff[Q_BITS];
endmodule

/* hdl/sip_checker.sv */
`include "assert_macros.svh"
module sip_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_hit,
   input logic [COORD_BITS-1:0] rsp_touch_x,
   input logic [COORD_BITS-1:0] rsp_touch_y
);
   import sip_pkg::*;
   `CHK_IMPLY(a_never_busy, clock, reset, 1'b1, !busy)
   `CHK_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_touch_x == '0 && rsp_touch_y == '0)
   `CHK_NEXT(a_rst_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule

bind segment_intersection_point sip_checker #(.COORD_BITS(COORD_BITS)) u_sip_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_hit(rsp_hit), .rsp_touch_x(rsp_touch_x), .rsp_touch_y(rsp_touch_y));
